@@ rtl/tdc_fc_pkg.sv @@
package tdc_fc_pkg;

  localparam int CODE_BITS  = 10;
  localparam int COUNT_BITS = 19;
  localparam int FRAC_BITS  = 16;
  localparam int NCODES     = 1 << CODE_BITS;
  localparam int SAMPLE_BITS = 17;

  localparam logic [CODE_BITS-1:0]   CODE_INVALID = {CODE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_WRAP  = SAMPLE_BITS'(100000);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_BACK  = SAMPLE_BITS'(10000);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_R1    = SAMPLE_BITS'(10);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_R2    = SAMPLE_BITS'(100);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_R3    = SAMPLE_BITS'(1000);

  localparam logic [15:0] SWAP_MIN_RESET   = 16'd1000;
  localparam logic [7:0]  SWAP_RATIO_RESET = 8'd100;

  localparam logic [0:0] REG_SWAP_MIN   = 1'b0;
  localparam logic [0:0] REG_SWAP_RATIO = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SWAP_RB,
    ST_BANK_CLR,
    ST_HIT_RD,
    ST_HIT_WR,
    ST_POST_RB,
    ST_LOOKUP,
    ST_DIV_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch input code
    logic clr_step;     // write zero at walk index, bank given by clr_bank
    logic clr_bank;
    logic walk_start;   // reset walk index / accumulator
    logic rb_step;      // rebuild walk step
    logic rb_finish;
    logic swap;         // toggle bank and reset bank stats
    logic hit_rd;
    logic hit_wr;
    logic lookup;
    logic div_start;
    logic out_load;
    logic out_zero;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic invalid;
    logic swap_due;
    logic walk_last;
    logic rb_due;
    logic rb_pipe_done;
    logic table_ready;
    logic div_done;
  } stat_t;

endpackage

@@ rtl/tdc_fc_ctrl.sv @@
module tdc_fc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tdc_fc_pkg::stat_t  stat,
  output tdc_fc_pkg::ctrl_t  ctrl
);

  tdc_fc_pkg::state_t state, state_next;
  logic out_full;
  logic out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tdc_fc_pkg::ST_CLEAR;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  // accept when idle and the output slot is free or being drained
  assign in_ready  = (state == tdc_fc_pkg::ST_IDLE) && (!out_full || out_ready);
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    case (state)
      tdc_fc_pkg::ST_CLEAR:    if (stat.walk_last) state_next = tdc_fc_pkg::ST_IDLE;
      tdc_fc_pkg::ST_IDLE:     if (in_valid && in_ready) state_next = tdc_fc_pkg::ST_CHECK;
      tdc_fc_pkg::ST_CHECK: begin
        if (stat.invalid)       state_next = tdc_fc_pkg::ST_OUT;
        else if (stat.swap_due) state_next = tdc_fc_pkg::ST_SWAP_RB;
        else                    state_next = tdc_fc_pkg::ST_HIT_RD;
      end
      tdc_fc_pkg::ST_SWAP_RB:  if (stat.rb_pipe_done) state_next = tdc_fc_pkg::ST_BANK_CLR;
      tdc_fc_pkg::ST_BANK_CLR: if (stat.walk_last) state_next = tdc_fc_pkg::ST_HIT_RD;
      tdc_fc_pkg::ST_HIT_RD:   state_next = tdc_fc_pkg::ST_HIT_WR;
      tdc_fc_pkg::ST_HIT_WR:   state_next = stat.rb_due ? tdc_fc_pkg::ST_POST_RB
                                                        : tdc_fc_pkg::ST_LOOKUP;
      tdc_fc_pkg::ST_POST_RB:  if (stat.rb_pipe_done) state_next = tdc_fc_pkg::ST_LOOKUP;
      tdc_fc_pkg::ST_LOOKUP:   state_next = stat.table_ready ? tdc_fc_pkg::ST_DIV_LOAD
                                                             : tdc_fc_pkg::ST_OUT;
      tdc_fc_pkg::ST_DIV_LOAD: state_next = tdc_fc_pkg::ST_DIV;
      tdc_fc_pkg::ST_DIV:      if (stat.div_done) state_next = tdc_fc_pkg::ST_OUT;
      tdc_fc_pkg::ST_OUT:      if (!out_full || out_ready) state_next = tdc_fc_pkg::ST_IDLE;
      default:                 state_next = tdc_fc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl = '0;
    out_full_next = out_full && !out_ready;
    case (state)
      tdc_fc_pkg::ST_CLEAR: begin
        ctrl.clr_step = 1'b1;
        ctrl.clr_bank = 1'b0;
      end
      tdc_fc_pkg::ST_IDLE: begin
        ctrl.capture    = in_valid && in_ready;
        ctrl.walk_start = 1'b1;
      end
      tdc_fc_pkg::ST_SWAP_RB: begin
        ctrl.rb_step   = 1'b1;
        ctrl.rb_finish = stat.rb_pipe_done;
        ctrl.swap      = stat.rb_pipe_done;
      end
      tdc_fc_pkg::ST_BANK_CLR: begin
        ctrl.clr_step = 1'b1;
        ctrl.clr_bank = 1'b1;
      end
      tdc_fc_pkg::ST_HIT_RD: ctrl.hit_rd = 1'b1;
      tdc_fc_pkg::ST_HIT_WR: ctrl.hit_wr = 1'b1;
      tdc_fc_pkg::ST_POST_RB: begin
        ctrl.rb_step   = 1'b1;
        ctrl.rb_finish = stat.rb_pipe_done;
      end
      tdc_fc_pkg::ST_LOOKUP:   ctrl.lookup = 1'b1;
      tdc_fc_pkg::ST_DIV_LOAD: ctrl.div_start = 1'b1;
      tdc_fc_pkg::ST_CHECK: ctrl.walk_start = 1'b1;
      tdc_fc_pkg::ST_OUT: begin
        if (!out_full || out_ready) begin
          ctrl.out_load = 1'b1;
          ctrl.out_zero = stat.invalid || !stat.table_ready;
          out_full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/tdc_fc_datapath.sv @@
module tdc_fc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tdc_fc_pkg::CODE_BITS-1:0]    fine_code,
  input  logic [15:0]                         swap_min_count,
  input  logic [7:0]                          swap_ratio,
  input  tdc_fc_pkg::ctrl_t                   ctrl,
  output tdc_fc_pkg::stat_t                   stat,
  output logic [tdc_fc_pkg::FRAC_BITS-1:0]    fine_fraction
);

  localparam int CB = tdc_fc_pkg::CODE_BITS;
  localparam int NB = tdc_fc_pkg::COUNT_BITS;
  localparam int FB = tdc_fc_pkg::FRAC_BITS;
  localparam int DW = FB + 1;
  localparam int DCB = $clog2(FB + 2);

  logic [NB-1:0] hist [0:2*tdc_fc_pkg::NCODES-1];
  logic [NB-1:0] cum  [0:tdc_fc_pkg::NCODES-1];

  logic [CB-1:0] code;
  logic          active;
  logic [NB-1:0] total [0:1];
  logic          empty [0:1];
  logic [CB-1:0] top   [0:1];
  logic [tdc_fc_pkg::SAMPLE_BITS-1:0] sample;
  logic          tbl_ready;
  logic [CB-1:0] tbl_top;
  logic [NB-1:0] tbl_total;

  // walk state
  logic [CB-1:0] widx;
  logic [CB-1:0] ridx;       // index of data arriving from memory
  logic          rvalid;
  logic          rlast;
  logic          issue_done;
  logic [NB:0]   acc;
  logic [NB-1:0] hist_q;
  logic [NB-1:0] cum_q;

  // swap compare: one registered product
  logic [CB+7:0] prod_full;
  assign prod_full = (CB+8)'(swap_ratio) * (CB+8)'(top[active]);

  logic [CB+7:0] prod_r;
  always_ff @(posedge clk) prod_r <= prod_full;

  assign stat.invalid  = (code == tdc_fc_pkg::CODE_INVALID);
  assign stat.swap_due = ({16'd0, total[active]} > {{NB{1'b0}}, swap_min_count}) &&
                         ({{(CB+8){1'b0}}, total[active]} > {{NB{1'b0}}, prod_r});
  assign stat.walk_last   = (widx == tdc_fc_pkg::CODE_INVALID);
  assign stat.table_ready = tbl_ready;

  logic [tdc_fc_pkg::SAMPLE_BITS-1:0] sample_inc;
  assign sample_inc = (sample + 1'b1 >= tdc_fc_pkg::SAMPLE_WRAP) ? tdc_fc_pkg::SAMPLE_BACK
                                                                 : sample + 1'b1;
  // rebuild points, seen while the hit is being written
  assign stat.rb_due = (sample_inc == tdc_fc_pkg::SAMPLE_R1) ||
                       (sample_inc == tdc_fc_pkg::SAMPLE_R2) ||
                       (sample_inc == tdc_fc_pkg::SAMPLE_R3) ||
                       (sample_inc == tdc_fc_pkg::SAMPLE_BACK);
  assign stat.rb_pipe_done = rvalid && rlast;

  logic [CB:0]   hit_addr;
  logic [CB:0]   rb_addr;
  assign hit_addr = {active, code};
  assign rb_addr  = {active, widx};

  // histogram memory: one port read, one port write
  always_ff @(posedge clk) begin
    if (ctrl.clr_step)
      hist[{(ctrl.clr_bank ? active : 1'b0), widx}] <= '0;
    else if (ctrl.hit_wr)
      hist[hit_addr] <= (hist_q == tdc_fc_pkg::COUNT_MAX) ? hist_q : hist_q + 1'b1;
    if (ctrl.hit_rd)
      hist_q <= hist[hit_addr];
    else if (ctrl.rb_step)
      hist_q <= hist[rb_addr];
  end

  // cumulative table memory
  logic [CB-1:0] lk_addr;
  assign lk_addr = (code < tbl_top) ? code : tbl_top;
  always_ff @(posedge clk) begin
    if (rvalid && ctrl.rb_step)
      cum[ridx] <= acc[NB-1:0];
    if (ctrl.lookup)
      cum_q <= cum[lk_addr];
  end

  logic [NB:0] acc_add;
  assign acc_add = acc + {1'b0, hist_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      total[0]  <= '0; total[1] <= '0;
      empty[0]  <= 1'b1; empty[1] <= 1'b1;
      top[0]    <= '0; top[1] <= '0;
      sample    <= '0;
      tbl_ready <= 1'b0;
      tbl_top   <= '0;
      tbl_total <= '0;
      widx      <= '0;
      rvalid    <= 1'b0;
      rlast     <= 1'b0;
      issue_done <= 1'b0;
      acc       <= '0;
    end else begin
      if (ctrl.capture) code <= fine_code;
      if (ctrl.walk_start || ctrl.hit_wr || ctrl.rb_finish) begin
        widx <= '0; rvalid <= 1'b0; rlast <= 1'b0; issue_done <= 1'b0; acc <= '0;
      end else if (ctrl.clr_step) begin
        widx <= widx + 1'b1;
      end else if (ctrl.rb_step) begin
        if (!issue_done) begin
          ridx   <= widx;
          rvalid <= 1'b1;
          rlast  <= (widx == top[active]);
          if (widx == top[active]) issue_done <= 1'b1;
          widx <= widx + 1'b1;
        end else begin
          rvalid <= 1'b0;
        end
        if (rvalid) acc <= acc_add[NB] ? {1'b0, tdc_fc_pkg::COUNT_MAX} : acc_add;
      end
      if (ctrl.rb_finish) begin
        tbl_ready <= 1'b1;
        tbl_top   <= top[active];
        tbl_total <= acc_add[NB] ? tdc_fc_pkg::COUNT_MAX : acc_add[NB-1:0];
      end
      if (ctrl.swap) begin
        active         <= ~active;
        total[~active] <= '0;
        empty[~active] <= 1'b1;
        top[~active]   <= '0;
      end
      if (ctrl.hit_wr) begin
        if (empty[active] || code > top[active]) top[active] <= code;
        empty[active] <= 1'b0;
        if (total[active] != tdc_fc_pkg::COUNT_MAX) total[active] <= total[active] + 1'b1;
        sample   <= sample_inc;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DW-1:0]  dnum;
  logic [NB:0]    drem;
  logic [FB:0]    dquo;
  logic [DCB-1:0] dcnt;
  logic           dbusy;
  logic [NB+1:0]  dtry;
  assign dtry = {drem, dnum[DW-1]} - {2'b00, tbl_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (ctrl.div_start) begin
      dbusy <= 1'b1;
      dcnt  <= DCB'(FB + 1);
      dnum  <= {cum_q[0], {FB{1'b0}}};
      drem  <= {2'b00, cum_q[NB-1:1]};
      dquo  <= '0;
    end else if (dbusy && dcnt != '0) begin
      if (!dtry[NB+1]) begin
        drem <= dtry[NB:0];
        dquo <= {dquo[FB-1:0], 1'b1};
      end else begin
        drem <= {drem[NB-1:0], dnum[DW-1]};
        dquo <= {dquo[FB-1:0], 1'b0};
      end
      dnum <= dnum << 1;
      dcnt <= dcnt - 1'b1;
    end
  end
  assign stat.div_done = dbusy && (dcnt == '0);

  // first step compares the whole table entry, the rest shift in fraction zeros
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      if (ctrl.out_zero || tbl_total == '0) fine_fraction <= '0;
      else if (dquo[FB])                    fine_fraction <= {FB{1'b1}};
      else                                  fine_fraction <= dquo[FB-1:0];
    end
  end

endmodule

@@ rtl/tdc_fine_time_calibrator_unit.sv @@
// tdc fine-time calibrator, code density method
// a valid code passes check, hit read/write, table lookup, divider load, divider and
// output (divider skipped without a table); the invalid code goes check to output
// a new request is taken only once the last result is loaded, later if output stalls
// a swap adds a rebuild walk and new-bank clear, a rebuild point a rebuild walk
// reset: synchronous; a clearing pass over histogram bank 0 runs after reset
module tdc_fine_time_calibrator_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tdc_fc_pkg::CODE_BITS-1:0] fine_code,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [tdc_fc_pkg::FRAC_BITS-1:0] fine_fraction,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  tdc_fc_pkg::ctrl_t ctrl;
  tdc_fc_pkg::stat_t stat;

  logic [15:0] swap_min_count;
  logic [7:0]  swap_ratio;

  // configuration registers at word-aligned byte addresses 0 and 4
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_min_count <= tdc_fc_pkg::SWAP_MIN_RESET;
      swap_ratio     <= tdc_fc_pkg::SWAP_RATIO_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == tdc_fc_pkg::REG_SWAP_MIN)   swap_min_count <= pwdata[15:0];
      if (paddr[2] == tdc_fc_pkg::REG_SWAP_RATIO) swap_ratio     <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == tdc_fc_pkg::REG_SWAP_MIN) prdata = {16'd0, swap_min_count};
      else                                      prdata = {24'd0, swap_ratio};
    end
  end

  tdc_fc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  tdc_fc_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .fine_code      (fine_code),
    .swap_min_count (swap_min_count),
    .swap_ratio     (swap_ratio),
    .ctrl           (ctrl),
    .stat           (stat),
    .fine_fraction  (fine_fraction)
  );

  // no new request while a result waits unless it drains this cycle
  assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_ready) else $error("accept over pending result");

  // a result only appears after the output register was loaded
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.out_load)) else $error("result without request");

  // output holds while stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fine_fraction))
    else $error("result dropped");

endmodule
